// ----- rtl/core/uer_pkg.sv -----
`timescale 1ns / 1ps

package uer_pkg;

   localparam int unsigned CountWidth = 17;
   localparam int unsigned DistWidth  = 21;
   localparam int unsigned ProdWidth  = 22;
   localparam int unsigned MaxCmWidth = 10;

   localparam logic [CountWidth-1:0] CountMax     = '1;
   localparam logic [ProdWidth-1:0]  DistMax      = ProdWidth'(2097151);
   localparam logic [ProdWidth-1:0]  MinDistMilli = ProdWidth'(2000);
   localparam logic [9:0]            MilliPerCm   = 10'd1000;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 17;

   // Register indexes on the configuration port.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_MAX_DISTANCE  = 3'd1,
      CSR_START_TIMEOUT = 3'd2,
      CSR_ECHO_TIMEOUT  = 3'd3,
      CSR_TRIGGER_WIDTH = 3'd4
   } uer_csr_index_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_NOT_READY     = 3'd1,
      ST_START_TIMEOUT = 3'd2,
      ST_ECHO_TIMEOUT  = 3'd3,
      ST_OUT_OF_RANGE  = 3'd4
   } uer_status_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TRIG = 4'b0010,
      PH_WAIT = 4'b0100,
      PH_MEAS = 4'b1000
   } uer_phase_type;

   typedef struct packed {
      logic                  enable;
      logic [MaxCmWidth-1:0] max_distance_cm;
      logic [15:0]           start_wait_limit;
      logic [16:0]           echo_len_limit;
      logic [7:0]            trigger_width_us;
   } uer_cfg_type;

   typedef struct packed {
      uer_phase_type         phase;
      logic [CountWidth-1:0] tick_count;
   } uer_state_type;

   // Packed so that the last field sits in the lowest bits of tdata.
   typedef struct packed {
      logic [DistWidth-1:0]  distance_milli_cm;
      logic [CountWidth-1:0] echo_ticks;
      uer_status_type        status;
      logic                  done_res;
      logic                  trigger_level;
   } uer_result_type;

   localparam int unsigned ResultWidth = $bits(uer_result_type);
   localparam int unsigned RspWidth    = ((ResultWidth + 7) / 8) * 8;

endpackage

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tdata[7:0]: one microsecond tick sample
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata[47:0]: trigger level, done, result
// csr       in         csr_valid/csr_ready    csr_index[2:0], csr_data[16:0]
//
// One tick transaction is taken every cycle while req_tready is high; each yields exactly
// one result transaction, presented on rsp after it has passed the input register and then
// the result register.
// The step logic updates phase and tick count in the cycle a tick leaves the input register,
// so consecutive ticks follow back to back through the same registers.
// A stall on rsp holds the result register and, behind it, the input register; req_tready
// drops only when both are full. Reset is synchronous and returns the phase to idle and
// every configuration register to its documented default. csr writes are always accepted.

module ultrasonic_echo_ranger
   import uer_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // [0] start_request, [1] echo_level, [7:2] zero
   input  logic [7:0]               req_tdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [0] trigger_level, [1] done_res, [4:2] status, [21:5] echo_ticks,
   // [42:22] distance_milli_cm, [47:43] zero
   output logic [RspWidth-1:0]      rsp_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   uer_cfg_type    cfg;
   uer_state_type  state_ff;
   uer_state_type  state_in;
   uer_state_type  state_next;
   uer_result_type step_result;
   uer_result_type result_ff;
   uer_result_type result_in;

   logic in_valid_ff;
   logic in_valid_in;
   logic in_start_ff;
   logic in_start_in;
   logic in_echo_ff;
   logic in_echo_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_free;
   logic in_free;
   logic advance;

   assign csr_ready = 1'b1;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   uer_step u_step (
      .cfg           (cfg),
      .state         (state_ff),
      .start_request (in_start_ff),
      .echo_level    (in_echo_ff),
      .state_next    (state_next),
      .result        (step_result)
   );

   // The result register frees up when it is empty or being drained this cycle.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_free;
   assign in_free    = !in_valid_ff || rsp_free;
   assign req_tready = in_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_start_in  = in_start_ff;
      in_echo_in   = in_echo_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      state_in     = state_ff;
      if (rsp_free) begin
         rsp_valid_in = advance;
      end
      if (advance) begin
         result_in = step_result;
         state_in  = state_next;
      end
      if (in_free) begin
         in_valid_in = req_tvalid;
         in_start_in = req_tdata[0];
         in_echo_in  = req_tdata[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         state_ff.phase      <= PH_IDLE;
         state_ff.tick_count <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_start_ff <= in_start_in;
      in_echo_ff  <= in_echo_in;
      result_ff   <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspWidth-ResultWidth){1'b0}}, result_ff};

endmodule

// ----- rtl/core/uer_csr.sv -----
`timescale 1ns / 1ps

module uer_csr
   import uer_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output uer_cfg_type              cfg
);

   uer_cfg_type cfg_ff;
   uer_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (uer_csr_index_type'(csr_index))
            CSR_ENABLE:        cfg_in.enable           = csr_data[0];
            CSR_MAX_DISTANCE:  cfg_in.max_distance_cm  = csr_data[MaxCmWidth-1:0];
            CSR_START_TIMEOUT: cfg_in.start_wait_limit = csr_data[15:0];
            CSR_ECHO_TIMEOUT:  cfg_in.echo_len_limit   = csr_data[16:0];
            CSR_TRIGGER_WIDTH: cfg_in.trigger_width_us = csr_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b1;
         cfg_ff.max_distance_cm  <= MaxCmWidth'(400);
         cfg_ff.start_wait_limit <= 16'd5000;
         cfg_ff.echo_len_limit   <= 17'd50000;
         cfg_ff.trigger_width_us <= 8'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/uer_step.sv -----
`timescale 1ns / 1ps

module uer_step
   import uer_pkg::*;
(
   input  uer_cfg_type    cfg,
   input  uer_state_type  state,
   input  logic           start_request,
   input  logic           echo_level,
   output uer_state_type  state_next,
   output uer_result_type result
);

   logic [CountWidth-1:0] count_inc;
   logic                  count_sat;
   logic [ProdWidth-1:0]  dist_raw;
   logic [ProdWidth-1:0]  dist_max_milli;
   logic [ProdWidth-1:0]  dist_clip;

   // The count holds at its top value instead of wrapping.
   assign count_sat = (state.tick_count == CountMax);
   assign count_inc = count_sat ? state.tick_count : state.tick_count + 1'b1;

   // Ticks times 17 as a shift and add.
   assign dist_raw = {1'b0, state.tick_count, 4'b0000}
                   + {{(ProdWidth-CountWidth){1'b0}}, state.tick_count};
   assign dist_max_milli = ProdWidth'(cfg.max_distance_cm) * ProdWidth'(MilliPerCm);
   assign dist_clip = (dist_raw > DistMax) ? DistMax : dist_raw;

   always_comb begin
      state_next = state;
      result     = '0;
      case (state.phase)
         PH_IDLE: begin
            if (start_request) begin
               if (!cfg.enable) begin
                  result.done_res = 1'b1;
                  result.status   = ST_NOT_READY;
               end else begin
                  result.trigger_level = 1'b1;
                  // A trigger width of zero or one ends the pulse right here.
                  if (cfg.trigger_width_us <= 8'd1) begin
                     state_next.phase      = PH_WAIT;
                     state_next.tick_count = '0;
                  end else begin
                     state_next.phase      = PH_TRIG;
                     state_next.tick_count = CountWidth'(1);
                  end
               end
            end
         end
         PH_TRIG: begin
            result.trigger_level = 1'b1;
            if (count_inc >= CountWidth'(cfg.trigger_width_us)) begin
               state_next.phase      = PH_WAIT;
               state_next.tick_count = '0;
            end else begin
               state_next.tick_count = count_inc;
            end
         end
         PH_WAIT: begin
            if (echo_level) begin
               state_next.phase      = PH_MEAS;
               state_next.tick_count = CountWidth'(1);
            end else if (count_inc > CountWidth'(cfg.start_wait_limit)) begin
               result.done_res       = 1'b1;
               result.status         = ST_START_TIMEOUT;
               state_next.phase      = PH_IDLE;
               state_next.tick_count = '0;
            end else begin
               state_next.tick_count = count_inc;
            end
         end
         PH_MEAS: begin
            if (echo_level) begin
               if (count_sat || (count_inc > cfg.echo_len_limit)) begin
                  result.done_res       = 1'b1;
                  result.status         = ST_ECHO_TIMEOUT;
                  result.echo_ticks     = count_inc;
                  state_next.phase      = PH_IDLE;
                  state_next.tick_count = '0;
               end else begin
                  state_next.tick_count = count_inc;
               end
            end else begin
               result.done_res          = 1'b1;
               result.echo_ticks        = state.tick_count;
               result.distance_milli_cm = dist_clip[DistWidth-1:0];
               if ((dist_raw < MinDistMilli) || (dist_raw > dist_max_milli)) begin
                  result.status = ST_OUT_OF_RANGE;
               end else begin
                  result.status = ST_OK;
               end
               state_next.phase      = PH_IDLE;
               state_next.tick_count = '0;
            end
         end
         default: begin
            state_next.phase      = PH_IDLE;
            state_next.tick_count = '0;
         end
      endcase
   end

endmodule

// ----- rtl/core/uer_checker.sv -----
`timescale 1ns / 1ps

module uer_checker
   import uer_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspWidth-1:0] rsp_tdata
);

   logic [2:0] rsp_status;
   assign rsp_status = rsp_tdata[4:2];

   // A stalled result must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Ticks that finish nothing carry no status, count or distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[42:2] == '0)
      else $error("result fields set without done");

   // Status codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_status <= ST_OUT_OF_RANGE)
      else $error("undefined status code");

   // Not-ready and start-timeout results report no echo at all.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1]
         && (rsp_status == ST_NOT_READY || rsp_status == ST_START_TIMEOUT)
      |-> rsp_tdata[42:5] == '0)
      else $error("echo data on a failed start");

   // The trigger is never driven on the tick a measurement finishes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("trigger high on a finishing tick");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/ultrasonic_echo_ranger_test.sv -----
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_test;
   import uer_pkg::*;

   // The run ends with a failure if it takes longer than this many clock cycles.
   // A correct run stays well within this even with the receiver stalling hard, so this leaves
   // ample margin.
   localparam int ClockLimit   = 200_000;
   // Thousandths of a centimetre per echo tick (0.034 cm/us halved).
   localparam int MilliPerTick = 17;
   // An index that names no register; a write to it must change nothing.
   localparam logic [CsrIndexWidth-1:0] CsrUnusedIndex = 3'd7;
   // Slots for expected results; far more than the block can hold in flight.
   localparam int PendDepth    = 8;

   // How the start request bit behaves on ticks after the one that starts a measurement.
   typedef enum logic [1:0] {
      START_LOW,
      START_HELD,
      START_RANDOM
   } start_mode_type;

   // Every input of the block has a known value from time zero.
   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic [7:0]               req_tdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RspWidth-1:0]      rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index  = CSR_ENABLE;
   logic [CsrDataWidth-1:0]  csr_data   = '0;

   // Shadow copy of the configuration registers and of the ranging state.
   uer_cfg_type           shadow_cfg;
   uer_phase_type         ranger_phase;
   logic [CountWidth-1:0] ranger_count;

   // Results expected from the block, kept in a ring; the writer and the reader each
   // own one running count.
   uer_result_type pending_results[PendDepth];
   int pend_wr = 0;
   int pend_rd = 0;

   int send_idle_pct  = 10;
   int recv_stall_pct = 78;
   int ticks_sent     = 0;
   int fail_count     = 0;
   int cycle_count    = 0;

   ultrasonic_echo_ranger uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // A 2 ns clock period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= ClockLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver stalls at random; the stall rate changes between test phases.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Ends a measurement: the result carries done, the status and the payload, and the
   // shadow state goes back to idle.
   function automatic uer_result_type close_run(input uer_status_type st,
                                                input logic [CountWidth-1:0] ticks,
                                                input logic [DistWidth-1:0] dist_out);
      uer_result_type r;
      r                   = '0;
      r.done_res          = 1'b1;
      r.status            = st;
      r.echo_ticks        = ticks;
      r.distance_milli_cm = dist_out;
      ranger_phase        = PH_IDLE;
      ranger_count        = '0;
      return r;
   endfunction

   // Advances the shadow ranger by one microsecond tick and returns the result that the
   // block must produce for it.
   function automatic uer_result_type predict_tick(input logic start, input logic echo);
      uer_result_type       r;
      logic [ProdWidth-1:0] milli;
      logic [ProdWidth-1:0] ceiling;
      logic                 saturated;
      r = '0;
      case (ranger_phase)
         PH_IDLE: begin
            if (start && !shadow_cfg.enable) begin
               // Sensor not ready: the request finishes at once without a trigger pulse.
               r = close_run(ST_NOT_READY, '0, '0);
            end else if (start) begin
               // The start tick is already the first trigger-high tick. A width of
               // zero behaves like a width of one.
               r.trigger_level = 1'b1;
               ranger_count    = CountWidth'(1);
               if (ranger_count >= CountWidth'(shadow_cfg.trigger_width_us)) begin
                  ranger_phase = PH_WAIT;
                  ranger_count = '0;
               end else begin
                  ranger_phase = PH_TRIG;
               end
            end
         end
         PH_TRIG: begin
            // Echo is ignored while the trigger is high.
            r.trigger_level = 1'b1;
            if (ranger_count != CountMax) ranger_count = ranger_count + 1'b1;
            if (ranger_count >= CountWidth'(shadow_cfg.trigger_width_us)) begin
               ranger_phase = PH_WAIT;
               ranger_count = '0;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               ranger_phase = PH_MEAS;
               ranger_count = CountWidth'(1);
            end else begin
               if (ranger_count != CountMax) ranger_count = ranger_count + 1'b1;
               if (ranger_count > CountWidth'(shadow_cfg.start_wait_limit)) begin
                  r = close_run(ST_START_TIMEOUT, '0, '0);
               end
            end
         end
         default: begin
            if (echo) begin
               // A count stuck at its maximum while echo stays high is a timeout too.
               saturated = (ranger_count == CountMax);
               if (!saturated) ranger_count = ranger_count + 1'b1;
               if (saturated || ranger_count > CountWidth'(shadow_cfg.echo_len_limit)) begin
                  r = close_run(ST_ECHO_TIMEOUT, ranger_count, '0);
               end
            end else begin
               // Falling edge: convert the pulse length and check it against the range.
               milli   = ProdWidth'(ranger_count) * ProdWidth'(MilliPerTick);
               ceiling = ProdWidth'(shadow_cfg.max_distance_cm) * ProdWidth'(MilliPerCm);
               r = close_run((milli < MinDistMilli || milli > ceiling) ?
                             ST_OUT_OF_RANGE : ST_OK,
                             ranger_count,
                             (milli > DistMax) ? DistWidth'(DistMax) : DistWidth'(milli));
            end
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] wanted,
                                       input logic [31:0] seen);
      if (wanted !== seen) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, name, wanted, seen);
      end
   endfunction

   // Each result transaction is compared with the oldest expectation, field by field.
   always @(posedge clock) begin
      uer_result_type seen;
      uer_result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[ResultWidth-1:0];
         if (pend_wr == pend_rd) begin
            fail_count++;
            $display("%0t ns: unexpected result transaction, expected none, actual %h",
                     $time, seen);
         end else begin
            wanted = pending_results[pend_rd % PendDepth];
            pend_rd++;
            check_field("trigger_level", 32'(wanted.trigger_level), 32'(seen.trigger_level));
            check_field("done_res", 32'(wanted.done_res), 32'(seen.done_res));
            check_field("status", 32'(wanted.status), 32'(seen.status));
            check_field("echo_ticks", 32'(wanted.echo_ticks), 32'(seen.echo_ticks));
            check_field("distance_milli_cm", 32'(wanted.distance_milli_cm),
                        32'(seen.distance_milli_cm));
         end
      end
   end

   // Sends one tick transaction. It is entered and left at a falling edge; the valid
   // stays high on return so that back-to-back ticks leave no gap.
   task automatic send_tick(input logic start, input logic echo);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {6'b0, echo, start};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results[pend_wr % PendDepth] = predict_tick(start, echo);
      pend_wr++;
      ticks_sent++;
      @(negedge clock);
   endtask

   function automatic logic start_bit(input start_mode_type mode);
      case (mode)
         START_HELD:   return 1'b1;
         START_RANDOM: return 1'($urandom_range(0, 1));
         default:      return 1'b0;
      endcase
   endfunction

   task automatic send_ticks(input int count, input logic echo, input start_mode_type mode);
      for (int i = 0; i < count; i++) send_tick(start_bit(mode), echo);
   endtask

   // A start tick followed by the rest of the trigger pulse, with echo noise that the
   // block must ignore while the trigger is high.
   task automatic send_trigger(input start_mode_type mode);
      int width;
      width = (shadow_cfg.trigger_width_us == 0) ? 1 : int'(shadow_cfg.trigger_width_us);
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      repeat (width - 1) send_tick(start_bit(mode), 1'($urandom_range(0, 1)));
   endtask

   // One complete measurement: trigger, low wait, high pulse and the falling edge.
   task automatic run_measure(input int wait_low, input int high_len,
                              input start_mode_type mode);
      send_trigger(mode);
      send_ticks(wait_low, 1'b0, mode);
      send_ticks(high_len, 1'b1, mode);
      send_ticks(1, 1'b0, mode);
   endtask

   // The sender holds off until every expected result has come back, which leaves the
   // pipeline empty.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pend_wr != pend_rd) @(negedge clock);
   endtask

   // One register write transaction. The valid stays high on return; the caller lowers it.
   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ENABLE:        shadow_cfg.enable           = value[0];
         CSR_MAX_DISTANCE:  shadow_cfg.max_distance_cm  = value[MaxCmWidth-1:0];
         CSR_START_TIMEOUT: shadow_cfg.start_wait_limit = value[15:0];
         CSR_ECHO_TIMEOUT:  shadow_cfg.echo_len_limit   = value[16:0];
         CSR_TRIGGER_WIDTH: shadow_cfg.trigger_width_us = value[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Rewrites every register once the block has nothing in flight. A write to an index
   // with no register is mixed in and must have no effect.
   task automatic configure(input logic [CsrDataWidth-1:0] en,
                            input logic [CsrDataWidth-1:0] max_cm,
                            input logic [CsrDataWidth-1:0] start_to,
                            input logic [CsrDataWidth-1:0] echo_to,
                            input logic [CsrDataWidth-1:0] trig_w);
      drain_results();
      write_reg(CSR_ENABLE, en);
      write_reg(CSR_MAX_DISTANCE, max_cm);
      write_reg(CsrUnusedIndex, CsrDataWidth'($urandom));
      write_reg(CSR_START_TIMEOUT, start_to);
      write_reg(CSR_ECHO_TIMEOUT, echo_to);
      write_reg(CSR_TRIGGER_WIDTH, trig_w);
      csr_valid <= 1'b0;
   endtask

   // Mostly small settings so that every outcome is reached within a few ticks, with the
   // full width of each register now and then and stray bits above the register width.
   task automatic randomize_registers();
      logic [CsrDataWidth-1:0] en, max_cm, start_to, echo_to, trig_w;
      en       = CsrDataWidth'($urandom_range(0, 9) != 0);
      max_cm   = CsrDataWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 4));
      start_to = CsrDataWidth'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 12));
      echo_to  = CsrDataWidth'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                           : $urandom_range(0, 200));
      trig_w   = CsrDataWidth'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 6));
      if ($urandom_range(0, 3) == 0) begin
         en       = en | (CsrDataWidth'($urandom) & ~17'h00001);
         max_cm   = max_cm | (CsrDataWidth'($urandom) & ~17'h003FF);
         start_to = start_to | (CsrDataWidth'($urandom) & ~17'h0FFFF);
         trig_w   = trig_w | (CsrDataWidth'($urandom) & ~17'h000FF);
      end
      configure(en, max_cm, start_to, echo_to, trig_w);
   endtask

   // Pulse lengths cluster at the short end and around the 2 cm lower limit.
   function automatic int pick_pulse();
      int pick;
      pick = int'($urandom_range(0, 19));
      if (pick < 12) return int'($urandom_range(0, 12));
      if (pick < 17) return int'($urandom_range(110, 190));
      return int'($urandom_range(13, 109));
   endfunction

   // Registers at their reset values, one clean measurement and one with start requests
   // held high throughout, which the busy block must ignore.
   task automatic test_power_on_defaults();
      run_measure(3, 120, START_LOW);
      run_measure(2, 20, START_HELD);
      send_ticks(2, 1'b0, START_LOW);
   endtask

   // With the sensor not ready each start request finishes on its own tick.
   task automatic test_not_ready();
      configure(0, 400, 5000, 50000, 10);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
   endtask

   // Trigger widths of zero, one and the largest register value.
   task automatic test_trigger_width();
      configure(1, 400, 5000, 50000, 0);
      run_measure(2, 20, START_LOW);
      configure(1, 400, 5000, 50000, 1);
      run_measure(0, 20, START_HELD);
      configure(1, 400, 5000, 50000, 255);
      run_measure(1, 20, START_LOW);
   endtask

   // Start timeouts of zero and one, and the edge of a small timeout on either side.
   task automatic test_start_timeout();
      configure(1, 400, 0, 50000, 2);
      run_measure(1, 10, START_LOW);
      configure(1, 400, 1, 50000, 2);
      run_measure(1, 20, START_LOW);
      run_measure(2, 20, START_LOW);
      configure(1, 400, 5, 50000, 3);
      run_measure(5, 20, START_LOW);
      run_measure(6, 20, START_LOW);
   endtask

   // Echo timeouts of zero and one, and a pulse exactly at a timeout and one tick past it.
   task automatic test_echo_timeout();
      configure(1, 400, 5000, 0, 1);
      run_measure(0, 1, START_LOW);
      run_measure(0, 2, START_LOW);
      configure(1, 400, 5000, 1, 1);
      run_measure(0, 2, START_LOW);
      configure(1, 1000, 5000, 30, 1);
      run_measure(0, 30, START_LOW);
      run_measure(0, 31, START_LOW);
   endtask

   // Distances just below and above the 2 cm floor and the configured ceiling, a pulse
   // that never rises, and a ceiling of zero.
   task automatic test_range_limits();
      configure(1, 3, 20, 50000, 1);
      run_measure(0, 117, START_LOW);
      run_measure(0, 118, START_LOW);
      run_measure(0, 176, START_LOW);
      run_measure(0, 177, START_LOW);
      run_measure(0, 1, START_LOW);
      run_measure(4, 0, START_LOW);
      configure(1, 0, 20, 50000, 1);
      run_measure(0, 20, START_LOW);
   endtask

   // Register changes while a measurement is under way take effect on the next tick:
   // a shorter trigger, a dropped enable, a new start timeout and a shorter echo timeout.
   task automatic test_mid_run_updates();
      configure(1, 400, 5000, 50000, 20);
      send_tick(1'b1, 1'b0);
      send_ticks(5, 1'b0, START_LOW);
      configure(1, 400, 5000, 50000, 3);
      send_ticks(2, 1'b0, START_LOW);
      configure(0, 400, 3, 50000, 3);
      send_ticks(1, 1'b0, START_LOW);
      send_ticks(30, 1'b1, START_LOW);
      configure(0, 400, 3, 20, 3);
      send_ticks(1, 1'b1, START_LOW);
      send_ticks(2, 1'b0, START_HELD);
      configure(1, 400, 3, 200, 3);
      run_measure(2, 40, START_LOW);
   endtask

   // Random traffic: mostly well-formed measurements with random content, broken up by
   // bursts of random ticks and by register changes in the gaps between them.
   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int item_count);
      int first;
      send_idle_pct  = sender_idle;
      recv_stall_pct = receiver_stall;
      first          = ticks_sent;
      while (ticks_sent - first < item_count) begin
         if ($urandom_range(0, 4) == 0) randomize_registers();
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 24)) begin
                  send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               end
            end
            1: begin
               // A measurement cut short; what follows lands in the middle of it.
               send_trigger(START_RANDOM);
               send_ticks(int'($urandom_range(0, 6)), 1'($urandom_range(0, 1)), START_RANDOM);
            end
            default: run_measure(int'($urandom_range(0, 8)), pick_pulse(), START_RANDOM);
         endcase
         send_ticks(int'($urandom_range(0, 4)), 1'($urandom_range(0, 1)), START_LOW);
      end
   endtask

   initial begin
      shadow_cfg.enable           = 1'b1;
      shadow_cfg.max_distance_cm  = 10'd400;
      shadow_cfg.start_wait_limit = 16'd5000;
      shadow_cfg.echo_len_limit   = 17'd50000;
      shadow_cfg.trigger_width_us = 8'd10;
      ranger_phase                = PH_IDLE;
      ranger_count                = '0;

      // Reset is held from time zero and released at a falling edge.
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed cases run with the sender idling lightly and the receiver stalling hard.
      test_power_on_defaults();
      test_not_ready();
      test_trigger_width();
      test_start_timeout();
      test_echo_timeout();
      test_range_limits();
      test_mid_run_updates();

      test_random_traffic(10, 78, 100);
      test_random_traffic(78, 10, 100);
      test_random_traffic(0, 0, 100);

      // Wait for the last results, then a little longer to catch any stray transaction.
      drain_results();
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
